// ===== rtl/sdbi_pkg.sv =====
// Package for the six-die bit index decoder.
// Holds the queue entry type, class and status codes and character constants.
`default_nettype none
package sdbi_pkg;

    localparam int FIFO_DEPTH = 4;

    localparam logic [7:0] CH_ONE  = 8'h31;
    localparam logic [7:0] CH_FOUR = 8'h34;
    localparam logic [7:0] CH_FIVE = 8'h35;
    localparam logic [7:0] CH_SIX  = 8'h36;

    localparam int IDX_W = 11;
    localparam int CNT_W = 16;

    typedef enum logic [1:0] {
        CLS_SKIP = 2'd0,
        CLS_DIE  = 2'd1,
        CLS_BAD  = 2'd2
    } cls_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_INVALID    = 2'd1,
        ST_INCOMPLETE = 2'd2,
        ST_CAPACITY   = 2'd3
    } status_t;

    typedef struct packed {
        cls_t       cls;
        logic [1:0] die_val;
        logic       reroll;
        logic       high_half;
        logic       last;
    } cmd_t;

endpackage
`default_nettype wire

// ===== rtl/six_die_bit_index_decoder.sv =====
// Six-die bit index decoder top level: front classifier, command queue, back end.
// Depends on sdbi_pkg, sdbi_front, sdbi_fifo and sdbi_back.
//
// Input stream: one ASCII character per beat in s_tdata[7:0]; s_tuser set when the
// character is present (clear for an end marker only); s_tlast ends the string.
// Output stream: one beat per completed index (m_tuser set, index in m_tdata[10:0])
// and one beat at end of string (m_tlast set, status in m_tdata[12:11], index
// count in m_tdata[28:13]); both can share one beat. Separators, rerolls and
// characters after an error give no beat.
// Each command goes through the command queue and is then popped into the output
// register that drives m_tvalid.
// Throughput: one beat per cycle unless stalled; group state changes on each pop.
// The command queue (FIFO_DEPTH entries) lets the input keep flowing while the
// output register waits on m_tready; once the queue fills, s_tready drops.
// Reset empties the queue and output register, clears group state and sets
// capacity_limit to 65535. cfg_we writes capacity_limit from cfg_wdata.
`default_nettype none
module six_die_bit_index_decoder #(
    parameter int FIFO_DEPTH = sdbi_pkg::FIFO_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_byte
    input  wire logic        s_tuser,   // [0] byte_present
    input  wire logic        s_tlast,   // end_of_string
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [10:0] word_index, [12:11] status,
                                        // [28:13] index_count, [31:29] zero
    output logic             m_tuser,   // [0] index_valid
    output logic             m_tlast    // done_res
);
    import sdbi_pkg::*;

    cmd_t push_cmd, pop_cmd;
    logic q_push, q_full, q_pop, q_empty;

    sdbi_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    sdbi_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .pop_cmd  (pop_cmd),
        .empty    (q_empty)
    );

    sdbi_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_cmd     (pop_cmd),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // a beat that does not end the string always carries an index
    a_beat_has_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tuser)
        else $error("result beat with neither index nor end of string");

    // count is reported only with ok status
    a_count_only_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[12:11] != ST_OK) |-> (m_tdata[28:13] == '0))
        else $error("index count nonzero with error status");

    // index field is zero without a new index
    a_idx_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> (m_tdata[10:0] == '0))
        else $error("word index nonzero without index_valid");

    // a pop needs a free output slot
    a_pop_room: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_empty && (!m_tvalid || m_tready))
        else $error("queue popped into a held output beat");

endmodule
`default_nettype wire

// ===== rtl/sdbi_front.sv =====
// Front end: accepts character beats and classifies them into queue commands.
// Depends on sdbi_pkg.
`default_nettype none
module sdbi_front (
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [7:0]       s_tdata,   // [7:0] char_byte
    input  wire logic             s_tuser,   // [0] byte_present
    input  wire logic             s_tlast,
    input  wire logic             q_full,
    output logic                  q_push,
    output sdbi_pkg::cmd_t        q_cmd
);
    import sdbi_pkg::*;

    logic       is_sep;
    logic       is_die;
    logic [7:0] offset;

    always_comb begin
        is_sep = s_tdata inside {8'h20, 8'h09, 8'h0D, 8'h0A, 8'h0B, 8'h0C,
                                 8'h2C, 8'h3B, 8'h7C};
        is_die = s_tdata inside {[CH_ONE:CH_SIX]};
        offset = s_tdata - CH_ONE;

        if (!s_tuser || is_sep) begin
            q_cmd.cls = CLS_SKIP;
        end else if (is_die) begin
            q_cmd.cls = CLS_DIE;
        end else begin
            q_cmd.cls = CLS_BAD;
        end
        q_cmd.die_val   = offset[1:0];
        q_cmd.reroll    = (s_tdata >= CH_FIVE);
        q_cmd.high_half = (s_tdata >= CH_FOUR);
        q_cmd.last      = s_tlast;
    end

    // skipped beats that do not end the string change nothing downstream
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full && !((q_cmd.cls == CLS_SKIP) && !s_tlast);

endmodule
`default_nettype wire

// ===== rtl/sdbi_fifo.sv =====
// Short command queue between front and back ends.
// Depends on sdbi_pkg for the entry type.
`default_nettype none
module sdbi_fifo #(
    parameter int DEPTH = sdbi_pkg::FIFO_DEPTH
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire sdbi_pkg::cmd_t push_cmd,
    output logic                full,
    input  wire logic           pop,
    output sdbi_pkg::cmd_t      pop_cmd,
    output logic                empty
);
    import sdbi_pkg::*;

    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);

    cmd_t              mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              do_push, do_pop;

    assign full    = (fill_reg == FILL_W'(DEPTH));
    assign empty   = (fill_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_cmd = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/sdbi_back.sv =====
// Back end: group state, index assembly, end-of-string status and output register.
// Depends on sdbi_pkg.
`default_nettype none
module sdbi_back (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           cfg_we,
    input  wire logic [15:0]    cfg_wdata,
    input  wire sdbi_pkg::cmd_t q_cmd,
    input  wire logic           q_empty,
    output logic                q_pop,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [31:0]         m_tdata,  // [10:0] word_index, [12:11] status,
                                          // [28:13] index_count, [31:29] zero
    output logic                m_tuser,  // [0] index_valid
    output logic                m_tlast   // done_res
);
    import sdbi_pkg::*;

    logic [CNT_W-1:0] cap_reg;
    logic [2:0]       dice_reg, dice_next;
    logic [9:0]       bits_reg, bits_next;
    logic             err_reg, err_next;
    logic [CNT_W-1:0] prod_reg, prod_next;
    logic             ovf_reg, ovf_next;

    logic             out_valid_reg;
    logic [IDX_W-1:0] out_idx_reg;
    status_t          out_st_reg;
    logic [CNT_W-1:0] out_cnt_reg;
    logic             out_iv_reg;
    logic             out_last_reg;

    logic             emit;
    logic [IDX_W-1:0] idx;
    status_t          st;
    logic [CNT_W-1:0] cnt;
    logic [CNT_W:0]   prod_inc;

    assign q_pop = !q_empty && (!out_valid_reg || m_tready);

    always_comb begin
        dice_next = dice_reg;
        bits_next = bits_reg;
        err_next  = err_reg;
        prod_next = prod_reg;
        ovf_next  = ovf_reg;
        emit      = 1'b0;
        idx       = '0;
        st        = ST_OK;
        cnt       = '0;
        prod_inc  = {1'b0, prod_reg} + 1'b1;

        if (!err_reg) begin
            case (q_cmd.cls)
                CLS_BAD: begin
                    err_next = 1'b1;
                end
                CLS_DIE: begin
                    if (dice_reg < 3'd5) begin
                        if (!q_cmd.reroll) begin
                            bits_next = {bits_reg[7:0], q_cmd.die_val};
                            dice_next = dice_reg + 1'b1;
                        end
                    end else begin
                        emit      = 1'b1;
                        idx       = {bits_reg, q_cmd.high_half};
                        prod_next = prod_inc[CNT_W-1:0];
                        if (prod_inc[CNT_W]) begin
                            ovf_next = 1'b1;
                        end
                        dice_next = '0;
                        bits_next = '0;
                    end
                end
                default: begin
                end
            endcase
        end

        if (q_cmd.last) begin
            if (err_next) begin
                st = ST_INVALID;
            end else if (dice_next != '0) begin
                st = ST_INCOMPLETE;
            end else if (ovf_next || (prod_next > cap_reg)) begin
                st = ST_CAPACITY;
            end else begin
                st = ST_OK;
            end
            cnt       = (st == ST_OK) ? prod_next : '0;
            dice_next = '0;
            bits_next = '0;
            err_next  = 1'b0;
            prod_next = '0;
            ovf_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg       <= '1;
            dice_reg      <= '0;
            bits_reg      <= '0;
            err_reg       <= 1'b0;
            prod_reg      <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                cap_reg <= cfg_wdata;
            end
            if (q_pop) begin
                dice_reg      <= dice_next;
                bits_reg      <= bits_next;
                err_reg       <= err_next;
                prod_reg      <= prod_next;
                ovf_reg       <= ovf_next;
                out_valid_reg <= emit || q_cmd.last;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            out_idx_reg  <= idx;
            out_st_reg   <= st;
            out_cnt_reg  <= cnt;
            out_iv_reg   <= emit;
            out_last_reg <= q_cmd.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_cnt_reg, out_st_reg, out_idx_reg};
    assign m_tuser  = out_iv_reg;
    assign m_tlast  = out_last_reg;

endmodule
`default_nettype wire
